/* hdl/abkf_pkg.sv */
// shared types, constants and helpers for the angle/bias kalman filter
package abkf_pkg;

  // value format: signed Q16.16
  localparam int VW = 32;
  localparam int FB = 16;
  localparam int REG_W = 31;
  localparam int TIME_W = 16;

  // divider operand widths: numerator holds |value| << FB
  localparam int NUM_W = 48;
  localparam int DEN_W = 33;

  // operand width of the shared multiplier (sums of two values)
  localparam int OP_W = VW + 1;
  localparam int SUM_W = VW + 4;

  // register reset values: round(noise * 2^FB)
  localparam logic [REG_W-1:0] ANGLE_Q_RST = 31'd66;
  localparam logic [REG_W-1:0] BIAS_Q_RST  = 31'd197;
  localparam logic [REG_W-1:0] MEAS_R_RST  = 31'd1966;

  // configuration register indexes
  localparam logic [1:0] REG_ANGLE_Q = 2'd0;
  localparam logic [1:0] REG_BIAS_Q  = 2'd1;
  localparam logic [1:0] REG_MEAS_R  = 2'd2;

  // microseconds to Q0.32 seconds, rounded: t * 2^32 / 10^6 splits into
  // t * 4294 plus (t * 967296 + 500000) / 10^6; the fraction part, reduced
  // by 64, is floor((t * 15114 + 7812) / 15625), found by a reciprocal
  // multiplication that is exact for numerators below 2^30
  localparam logic [28:0] DT_INT_MUL  = 29'd4294;
  localparam logic [29:0] DT_FRAC_MUL = 30'd15114;
  localparam logic [29:0] DT_FRAC_RND = 30'd7812;
  localparam logic [30:0] DT_RECIP    = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam int DT_RECIP_SH = 44;
  localparam int DT_PROD_W   = 61;

  // multiply steps of one filter update
  localparam logic [3:0] STEP_ANGLE_PRED = 4'd0;
  localparam logic [3:0] STEP_CROSS_PRED = 4'd1;
  localparam logic [3:0] STEP_AA_NOISE   = 4'd2;
  localparam logic [3:0] STEP_BB_PRED    = 4'd3;
  localparam logic [3:0] STEP_BB_NOISE   = 4'd4;
  localparam logic [3:0] STEP_ANGLE_CORR = 4'd5;
  localparam logic [3:0] STEP_BIAS_CORR  = 4'd6;
  localparam logic [3:0] STEP_AA_CORR    = 4'd7;
  localparam logic [3:0] STEP_AB_CORR    = 4'd8;
  localparam logic [3:0] STEP_BA_CORR    = 4'd9;
  localparam logic [3:0] STEP_BB_CORR    = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DT,
    ST_DT_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_OUT
  } abkf_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic start;
    logic frac_shift;  // shift by FB instead of 32
  } abkf_mul_req_t;

  // saturate a wide sum to the value range
  function automatic logic signed [VW-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] vmax;
    logic signed [SUM_W-1:0] vmin;
    vmax = SUM_W'((65'sd1 <<< (VW - 1)) - 65'sd1);
    vmin = -vmax - SUM_W'(1);
    if (v > vmax) return vmax[VW-1:0];
    else if (v < vmin) return vmin[VW-1:0];
    else return v[VW-1:0];
  endfunction

endpackage

/* hdl/angle_bias_kalman_filter.sv */
// two-state angle/gyro-bias kalman filter top level with step sequencer
// Each beat is worked through before the next one can be taken: the loop time is
// turned into Q0.32 seconds by a reciprocal multiplication, the eleven products
// of the predict and correct phases run one after another through one two-stage
// multiplier, and the two gains come from one bit-serial divider.
// in_tready is high only while the filter is idle; a finished result sits in
// the output register until taken, and the next beat is accepted meanwhile,
// but a result still waiting there holds the filter in its output step.
// Noise registers may be written whenever the filter is idle; values are
// signed Q16.16.
module angle_bias_kalman_filter import abkf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // measured_angle [31:0], measured_rate [63:32], loop_time_us [79:64]
  input  logic [79:0]      in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // angle_estimate [31:0], bias_estimate [63:32]
  output logic [63:0]      out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata
);

  abkf_state_t state_r, state_nxt;

  logic signed [VW-1:0]   angle_r, angle_nxt, bias_r, bias_nxt;
  logic signed [VW-1:0]   caa_r, caa_nxt, cab_r, cab_nxt, cba_r, cba_nxt, cbb_r, cbb_nxt;
  logic [REG_W-1:0]       qa_r, qb_r, rn_r;
  logic signed [VW-1:0]   z_r, rate_r;
  logic [TIME_W-1:0]      t_r;
  logic signed [VW-1:0]   dt_r, dt_nxt, tmp_r, tmp_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [VW:0]     y_r, y_nxt;
  logic signed [VW+1:0]   s_r, s_nxt;
  logic [3:0]             step_r, step_nxt;
  logic                   dsel_r, dsel_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [63:0]            out_data_r, out_data_nxt;

  abkf_mul_req_t          mul_req;
  logic signed [OP_W-1:0] mul_a, mul_b;
  logic                   mul_done;
  logic signed [VW-1:0]   mul_res;
  logic signed [SUM_W-1:0] m_ext;

  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_neg;
  logic                   div_done;
  logic signed [VW-1:0]   div_res;
  logic signed [VW-1:0]   gnum;
  logic [VW-1:0]          gnum_mag;

  logic                   dt_go;
  logic                   dtv1_r, dtv2_r;
  logic [29:0]            dtn_r;
  logic [28:0]            dtb_r;
  logic [DT_PROD_W-1:0]   dtp_r;
  logic [VW-1:0]          dt_conv;

  logic                   in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  abkf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  abkf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_num),
    .den_mag (div_den),
    .neg     (div_neg),
    .done    (div_done),
    .quot    (div_res)
  );

  // multiplier operand select per step
  always_comb begin
    mul_a = OP_W'(dt_r);
    mul_b = '0;
    case (step_r)
      STEP_ANGLE_PRED: mul_b = OP_W'(rate_r) - OP_W'(bias_r);
      STEP_CROSS_PRED: mul_b = OP_W'(cba_r) + OP_W'(cab_r);
      STEP_AA_NOISE:   mul_b = $signed({2'b00, qa_r});
      STEP_BB_PRED:    mul_b = OP_W'(cbb_r);
      STEP_BB_NOISE:   mul_b = $signed({2'b00, qb_r});
      STEP_ANGLE_CORR: begin mul_a = OP_W'(k0_r); mul_b = y_r; end
      STEP_BIAS_CORR:  begin mul_a = OP_W'(k1_r); mul_b = y_r; end
      STEP_AA_CORR:    begin mul_a = OP_W'(k0_r); mul_b = OP_W'(caa_r); end
      STEP_AB_CORR:    begin mul_a = OP_W'(k0_r); mul_b = OP_W'(cab_r); end
      STEP_BA_CORR:    begin mul_a = OP_W'(k1_r); mul_b = OP_W'(caa_r); end
      STEP_BB_CORR:    begin mul_a = OP_W'(k1_r); mul_b = OP_W'(cab_r); end
      default:         mul_b = '0;
    endcase
  end

  // divider operands: one of the two gains
  always_comb begin
    gnum     = dsel_r ? cba_r : caa_r;
    gnum_mag = gnum[VW-1] ? VW'(-gnum) : VW'(gnum);
    div_num  = NUM_W'(gnum_mag) << FB;
    div_den  = s_r[VW+1] ? DEN_W'(-s_r) : DEN_W'(s_r);
    div_neg  = gnum[VW-1] ^ s_r[VW+1];
  end

  // loop time to seconds: integer part and reciprocal-multiplied fraction part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtv1_r <= 1'b0;
      dtv2_r <= 1'b0;
    end else begin
      dtv1_r <= dt_go;
      dtv2_r <= dtv1_r;
    end
    dtn_r <= 30'(t_r) * DT_FRAC_MUL + DT_FRAC_RND;
    dtb_r <= 29'(t_r) * DT_INT_MUL;
    dtp_r <= DT_PROD_W'(dtn_r) * DT_PROD_W'(DT_RECIP);
  end

  assign dt_conv = VW'(dtb_r) + VW'(dtp_r[DT_PROD_W-1:DT_RECIP_SH]);

  assign m_ext = SUM_W'(mul_res);

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    angle_nxt     = angle_r;
    bias_nxt      = bias_r;
    caa_nxt       = caa_r;
    cab_nxt       = cab_r;
    cba_nxt       = cba_r;
    cbb_nxt       = cbb_r;
    dt_nxt        = dt_r;
    tmp_nxt       = tmp_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    y_nxt         = y_r;
    s_nxt         = s_r;
    step_nxt      = step_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    div_start     = 1'b0;
    dt_go         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DT;
      end
      ST_DT: begin
        dt_go     = 1'b1;
        state_nxt = ST_DT_WAIT;
      end
      ST_DT_WAIT: begin
        if (dtv2_r) begin
          dt_nxt    = $signed(dt_conv);
          step_nxt  = STEP_ANGLE_PRED;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_req.start      = 1'b1;
        mul_req.frac_shift = (step_r >= STEP_ANGLE_CORR);
        state_nxt          = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          step_nxt  = step_r + 4'd1;
          state_nxt = ST_MUL;
          case (step_r)
            STEP_ANGLE_PRED: angle_nxt = sat_val(SUM_W'(angle_r) + m_ext);
            STEP_CROSS_PRED: tmp_nxt = mul_res;
            STEP_AA_NOISE:   caa_nxt = sat_val(SUM_W'(caa_r) - SUM_W'(tmp_r) + m_ext);
            STEP_BB_PRED: begin
              cab_nxt = sat_val(SUM_W'(cab_r) - m_ext);
              cba_nxt = sat_val(SUM_W'(cba_r) - m_ext);
            end
            STEP_BB_NOISE: begin
              cbb_nxt   = sat_val(SUM_W'(cbb_r) + m_ext);
              y_nxt     = (VW+1)'(z_r) - (VW+1)'(angle_r);
              s_nxt     = (VW+2)'(caa_r) + $signed({3'b000, rn_r});
              dsel_nxt  = 1'b0;
              state_nxt = ST_DIV;
            end
            STEP_ANGLE_CORR: angle_nxt = sat_val(SUM_W'(angle_r) + m_ext);
            STEP_BIAS_CORR:  bias_nxt = sat_val(SUM_W'(bias_r) + m_ext);
            STEP_AA_CORR:    caa_nxt = sat_val(SUM_W'(caa_r) - m_ext);
            STEP_AB_CORR:    cab_nxt = sat_val(SUM_W'(cab_r) - m_ext);
            STEP_BA_CORR:    cba_nxt = sat_val(SUM_W'(cba_r) - m_ext);
            STEP_BB_CORR: begin
              cbb_nxt   = sat_val(SUM_W'(cbb_r) - m_ext);
              state_nxt = ST_OUT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!dsel_r) begin
            k0_nxt    = div_res;
            dsel_nxt  = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            k1_nxt    = div_res;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {bias_r, angle_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      bias_r      <= '0;
      caa_r       <= '0;
      cab_r       <= '0;
      cba_r       <= '0;
      cbb_r       <= '0;
      qa_r        <= ANGLE_Q_RST;
      qb_r        <= BIAS_Q_RST;
      rn_r        <= MEAS_R_RST;
      step_r      <= '0;
      dsel_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      bias_r      <= bias_nxt;
      caa_r       <= caa_nxt;
      cab_r       <= cab_nxt;
      cba_r       <= cba_nxt;
      cbb_r       <= cbb_nxt;
      step_r      <= step_nxt;
      dsel_r      <= dsel_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ANGLE_Q: qa_r <= cfg_wdata;
          REG_BIAS_Q:  qb_r <= cfg_wdata;
          REG_MEAS_R:  rn_r <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      z_r    <= $signed(in_tdata[31:0]);
      rate_r <= $signed(in_tdata[63:32]);
      t_r    <= in_tdata[79:64];
    end
    dt_r       <= dt_nxt;
    tmp_r      <= tmp_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    y_r        <= y_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL_WAIT)
    else $error("multiplier result outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider result outside its wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DT)
    else $error("accepted beat did not start the update");

  a_out_load_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output step");

endmodule

/* hdl/abkf_mul.sv */
// shared two-stage signed multiplier with rounding shift and saturation
module abkf_mul import abkf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abkf_mul_req_t        req,
  input  logic signed [OP_W-1:0] op_a,
  input  logic signed [OP_W-1:0] op_b,
  output logic                 done,
  output logic signed [VW-1:0] result
);

  localparam int PROD_W = 2 * OP_W;

  logic [OP_W-1:0]   mag_a;
  logic [OP_W-1:0]   mag_b;
  logic              v1_r;
  logic              neg1_r;
  logic              fsh1_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W:0]   rounded;
  logic [PROD_W:0]   shifted;
  logic [PROD_W:0]   lim;
  logic [VW-1:0]     mag_sat;
  logic              done_r;
  logic signed [VW-1:0] res_r;

  // operand magnitudes
  assign mag_a = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
  assign mag_b = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);

  // stage one: product of magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.start;
    end
    neg1_r <= op_a[OP_W-1] ^ op_b[OP_W-1];
    fsh1_r <= req.frac_shift;
    prod_r <= mag_a * mag_b;
  end

  // stage two: round half away from zero, shift, saturate, apply sign
  always_comb begin
    rounded = {1'b0, prod_r} + (fsh1_r ? ((PROD_W+1)'(1) << (FB - 1))
                                       : ((PROD_W+1)'(1) << 31));
    shifted = fsh1_r ? (rounded >> FB) : (rounded >> 32);
    lim = ((PROD_W+1)'(1) << (VW - 1)) - (PROD_W+1)'(!neg1_r);
    mag_sat = (shifted > lim) ? lim[VW-1:0] : shifted[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= v1_r;
    end
    res_r <= neg1_r ? -$signed(mag_sat) : $signed(mag_sat);
  end

  assign done = done_r;
  assign result = res_r;

endmodule

/* hdl/abkf_div.sv */
// radix-2 restoring divider, one quotient bit per cycle, signed saturated result
module abkf_div import abkf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num_mag,
  input  logic [DEN_W-1:0]     den_mag,
  input  logic                 neg,
  output logic                 done,
  output logic signed [VW-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;
  logic [NUM_W-1:0] lim;
  logic [NUM_W-1:0] mag_sat;

  // trial subtract
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den_mag;
      neg_r <= neg;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  // saturate and sign; a zero divisor gives zero
  always_comb begin
    lim = (NUM_W'(1) << (VW - 1)) - NUM_W'(!neg_r);
    mag_sat = (quo_r > lim) ? lim : quo_r;
    if (den_r == '0) quot = '0;
    else if (neg_r) quot = -$signed(mag_sat[VW-1:0]);
    else quot = $signed(mag_sat[VW-1:0]);
  end

  assign done = done_r;

endmodule
